// ===== design/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/gtpc_pkg.sv =====
`default_nettype none
package gtpc_pkg;

    typedef enum logic [3:0] {
        MAP_JET    = 4'd0,
        MAP_HOT    = 4'd1,
        MAP_HSV    = 4'd2,
        MAP_COOL   = 4'd3,
        MAP_SPRING = 4'd4,
        MAP_SUMMER = 4'd5,
        MAP_AUTUMN = 4'd6,
        MAP_WINTER = 4'd7,
        MAP_BONE   = 4'd8
    } map_t;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        sector_t    sector;
        logic [5:0] offset;
        logic       black;
    } hsv_pos_t;

    localparam int unsigned HUE_MULT    = 1480344;
    localparam int unsigned HUE_LIMIT   = 360;
    localparam int unsigned SECTOR_SPAN = 60;
    localparam int unsigned RAMP_MULT   = 4369;
    localparam int unsigned RAMP_ROUND  = 2;
    localparam int unsigned DIV5_MULT   = 205;

    function automatic logic [7:0] hsv_ramp(input logic [5:0] f);
        logic [18:0] p;
        p = 19'(RAMP_MULT) * 19'(f) + 19'(RAMP_ROUND);
        return p[17:10];
    endfunction

endpackage
`default_nettype wire

// ===== design/gtpc_lin_map.sv =====
`default_nettype none
module gtpc_lin_map (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [3:0]    color_map,
    input  wire logic [7:0]    gray_value,
    output gtpc_pkg::rgb_t     lin_rgb
);

    gtpc_pkg::rgb_t lin_rgb_reg;
    gtpc_pkg::rgb_t lin_rgb_next;

    logic        above;
    logic        below;
    logic [7:0]  d_pos;
    logic [7:0]  d_neg;
    logic [7:0]  abs_d;
    logic [7:0]  jet_t;
    logic [15:0] jet_rp;
    logic [15:0] jet_gp;
    logic [15:0] jet_bp;
    logic [7:0]  jet_r;
    logic [7:0]  jet_g;
    logic [7:0]  jet_b;
    logic [9:0]  t3;
    logic [9:0]  t3_g;
    logic [9:0]  t3_b;
    logic [7:0]  hot_r;
    logic [7:0]  hot_g;
    logic [7:0]  hot_b;
    logic [15:0] div5_p;
    logic [5:0]  q5;
    logic [8:0]  bone_rs;
    logic [8:0]  bone_gs;
    logic [7:0]  bone_r;
    logic [7:0]  bone_g;

    always_comb begin
        above  = gray_value > 8'd128;
        below  = gray_value < 8'd128;
        d_pos  = gray_value - 8'd128;
        d_neg  = 8'd128 - gray_value;
        abs_d  = above ? d_pos : d_neg;
        jet_t  = 8'd255 - abs_d;
        jet_rp = {d_pos, 8'd0} - 16'(d_pos);
        jet_gp = {jet_t, 8'd0} - 16'(jet_t);
        jet_bp = {d_neg, 8'd0} - 16'(d_neg);
        jet_r  = above ? jet_rp[14:7] : 8'd0;
        jet_g  = jet_gp[15] ? 8'd255 : jet_gp[14:7];
        jet_b  = below ? jet_bp[14:7] : 8'd0;

        t3    = 10'(gray_value) + {1'b0, gray_value, 1'b0};
        t3_g  = t3 - 10'd255;
        t3_b  = t3 - 10'd510;
        hot_r = (t3 > 10'd255) ? 8'd255 : t3[7:0];
        hot_g = (t3 < 10'd255) ? 8'd0 : ((t3_g > 10'd255) ? 8'd255 : t3_g[7:0]);
        hot_b = (t3 < 10'd510) ? 8'd0 : t3_b[7:0];

        div5_p  = 16'(gray_value) * 16'(gtpc_pkg::DIV5_MULT);
        q5      = div5_p[15:10];
        bone_rs = 9'(gray_value) + 9'(q5);
        bone_gs = 9'(gray_value) + 9'(q5[5:1]);
        bone_r  = bone_rs[8] ? 8'd255 : bone_rs[7:0];
        bone_g  = bone_gs[8] ? 8'd255 : bone_gs[7:0];

        lin_rgb_next = '0;
        unique case (gtpc_pkg::map_t'(color_map))
            gtpc_pkg::MAP_JET: begin
                lin_rgb_next = '{jet_r, jet_g, jet_b};
            end
            gtpc_pkg::MAP_HOT: begin
                lin_rgb_next = '{hot_r, hot_g, hot_b};
            end
            gtpc_pkg::MAP_COOL: begin
                lin_rgb_next = '{gray_value, 8'd255 - gray_value, 8'd255};
            end
            gtpc_pkg::MAP_SPRING: begin
                lin_rgb_next = '{8'd255, gray_value, 8'd255 - gray_value};
            end
            gtpc_pkg::MAP_SUMMER: begin
                lin_rgb_next = '{{1'b1, gray_value[7:1]}, {1'b1, gray_value[7:1]}, 8'd128};
            end
            gtpc_pkg::MAP_AUTUMN: begin
                lin_rgb_next = '{8'd255, gray_value, 8'd0};
            end
            gtpc_pkg::MAP_WINTER: begin
                lin_rgb_next = '{8'd0, gray_value, 8'd255 - gray_value};
            end
            gtpc_pkg::MAP_BONE: begin
                lin_rgb_next = '{bone_r, bone_g, gray_value};
            end
            default: begin
                lin_rgb_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lin_rgb_reg <= lin_rgb_next;
        end
    end

    assign lin_rgb = lin_rgb_reg;

endmodule
`default_nettype wire

// ===== design/gtpc_hsv_sector.sv =====
`default_nettype none
module gtpc_hsv_sector (
    input  wire logic         aclk,
    input  wire logic         en_hue,
    input  wire logic         en_pos,
    input  wire logic [7:0]   gray_value,
    output gtpc_pkg::hsv_pos_t pos
);

    logic [28:0] hue_prod;
    logic [8:0]  hue_reg;
    logic [8:0]  hue_next;
    logic [8:0]  base;
    logic [8:0]  off_full;

    gtpc_pkg::hsv_pos_t pos_reg;
    gtpc_pkg::hsv_pos_t pos_next;

    always_comb begin
        hue_prod = 29'(gray_value) * 29'(gtpc_pkg::HUE_MULT);
        hue_next = hue_prod[28:20];
    end

    always_comb begin
        pos_next.black = hue_reg >= 9'(gtpc_pkg::HUE_LIMIT);
        if (hue_reg >= 9'(5 * gtpc_pkg::SECTOR_SPAN)) begin
            pos_next.sector = gtpc_pkg::SEC_MAGENTA;
            base            = 9'(5 * gtpc_pkg::SECTOR_SPAN);
        end else if (hue_reg >= 9'(4 * gtpc_pkg::SECTOR_SPAN)) begin
            pos_next.sector = gtpc_pkg::SEC_BLUE;
            base            = 9'(4 * gtpc_pkg::SECTOR_SPAN);
        end else if (hue_reg >= 9'(3 * gtpc_pkg::SECTOR_SPAN)) begin
            pos_next.sector = gtpc_pkg::SEC_CYAN;
            base            = 9'(3 * gtpc_pkg::SECTOR_SPAN);
        end else if (hue_reg >= 9'(2 * gtpc_pkg::SECTOR_SPAN)) begin
            pos_next.sector = gtpc_pkg::SEC_GREEN;
            base            = 9'(2 * gtpc_pkg::SECTOR_SPAN);
        end else if (hue_reg >= 9'(gtpc_pkg::SECTOR_SPAN)) begin
            pos_next.sector = gtpc_pkg::SEC_YELLOW;
            base            = 9'(gtpc_pkg::SECTOR_SPAN);
        end else begin
            pos_next.sector = gtpc_pkg::SEC_RED;
            base            = 9'd0;
        end
        off_full       = hue_reg - base;
        pos_next.offset = off_full[5:0];
    end

    always_ff @(posedge aclk) begin
        if (en_hue) begin
            hue_reg <= hue_next;
        end
        if (en_pos) begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule
`default_nettype wire

// ===== design/gray_to_pseudo_color_map.sv =====
`default_nettype none
// Gray-to-pseudo-color mapper: each 8-bit gray item becomes one RGB item through the
// colormap held in the color_map register (0 jet, 1 hot, 2 hsv, 3 cool, 4 spring,
// 5 summer, 6 autumn, 7 winter, 8 bone; other codes give black). The datapath is a
// three-stage pipeline with a per-stage ready chain, so one item is taken every clock
// while the output is not stalled. An item passes the stage 1, stage 2 and output
// registers in turn and leaves when m_ready is high; a stalled output still lets items
// fill empty stages. The register is written through the cfg channel, which is always
// ready, and should only change while no items are in flight.
`include "assert_macros.svh"
module gray_to_pseudo_color_map (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_color_map,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_gray_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue
);

    logic [3:0] color_map_reg;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    logic       hsv1_reg;
    logic       hsv2_reg;
    logic       rdy1;
    logic       rdy2;
    logic       rdy3;
    logic       hsv_load;
    logic       out_black;
    logic       out_full;

    gtpc_pkg::rgb_t     lin1;
    gtpc_pkg::rgb_t     lin2_reg;
    gtpc_pkg::hsv_pos_t pos2;
    gtpc_pkg::rgb_t     hsv_rgb;
    gtpc_pkg::rgb_t     out_reg;
    gtpc_pkg::rgb_t     out_next;
    logic [7:0]         rise;
    logic [7:0]         fall;

    assign cfg_ready = 1'b1;
    assign rdy3      = !v3_reg || m_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign s_ready   = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_map_reg <= 4'(gtpc_pkg::MAP_JET);
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                color_map_reg <= cfg_color_map;
            end
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    gtpc_lin_map u_lin_map (
        .aclk       (aclk),
        .en         (rdy1),
        .color_map  (color_map_reg),
        .gray_value (s_gray_value),
        .lin_rgb    (lin1)
    );

    gtpc_hsv_sector u_hsv_sector (
        .aclk       (aclk),
        .en_hue     (rdy1),
        .en_pos     (rdy2),
        .gray_value (s_gray_value),
        .pos        (pos2)
    );

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            hsv1_reg <= color_map_reg == 4'(gtpc_pkg::MAP_HSV);
        end
        if (rdy2) begin
            hsv2_reg <= hsv1_reg;
            lin2_reg <= lin1;
        end
        if (rdy3) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        rise = gtpc_pkg::hsv_ramp(pos2.offset);
        fall = gtpc_pkg::hsv_ramp(6'(gtpc_pkg::SECTOR_SPAN) - pos2.offset);
        case (pos2.sector)
            gtpc_pkg::SEC_RED:    hsv_rgb = '{8'd255, rise, 8'd0};
            gtpc_pkg::SEC_YELLOW: hsv_rgb = '{fall, 8'd255, 8'd0};
            gtpc_pkg::SEC_GREEN:  hsv_rgb = '{8'd0, 8'd255, rise};
            gtpc_pkg::SEC_CYAN:   hsv_rgb = '{8'd0, fall, 8'd255};
            gtpc_pkg::SEC_BLUE:   hsv_rgb = '{rise, 8'd0, 8'd255};
            default:              hsv_rgb = '{8'd255, 8'd0, fall};
        endcase
        if (hsv2_reg) begin
            out_next = pos2.black ? '0 : hsv_rgb;
        end else begin
            out_next = lin2_reg;
        end
    end

    assign m_valid = v3_reg;
    assign m_red   = out_reg.red;
    assign m_green = out_reg.green;
    assign m_blue  = out_reg.blue;

    assign hsv_load  = rdy3 && v2_reg && hsv2_reg;
    assign out_black = m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0;
    assign out_full  = m_red == 8'd255 || m_green == 8'd255 || m_blue == 8'd255;

    `ASSERT_CLK(a_accept_fills_stage1, (s_valid && s_ready) |=> v1_reg, "item lost at stage 1")
    `ASSERT_CLK(a_hsv_black, (hsv_load && pos2.black) |=> out_black, "hue of 360 must give black")
    `ASSERT_CLK(a_hsv_full, (hsv_load && !pos2.black) |=> out_full, "hsv color lacks a full value")
    `ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "output valid after reset")

endmodule
`default_nettype wire

// ===== tb/gray_to_pseudo_color_map_test.sv =====
module gray_to_pseudo_color_map_test;

    localparam logic [3:0] UNUSED_MAP_LO = 4'd9;
    localparam logic [3:0] UNUSED_MAP_HI = 4'd15;
    localparam int PROBE_COUNT = 24;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASE_COUNT = 18;
    localparam int LONG_HOLD = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [3:0]     map;
        logic [7:0]     gray;
        bit             typed;
        gtpc_pkg::rgb_t color;
    } probe_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_color_map;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_gray_value;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;

    gtpc_pkg::rgb_t expected_colors[$];
    logic [3:0]     cur_map;
    int             errors;
    int             n_items;
    int             n_checked;
    int             quiet_cycles;
    bit             send_idling;
    bit             recv_idling;
    bit             hold_request;

    probe_t probes [PROBE_COUNT] = '{
        '{gtpc_pkg::MAP_JET,    8'd0,   1'b1, {8'd0,   8'd253, 8'd255}},
        '{gtpc_pkg::MAP_JET,    8'd255, 1'b1, {8'd253, 8'd255, 8'd0}},
        '{gtpc_pkg::MAP_JET,    8'd128, 1'b1, {8'd0,   8'd255, 8'd0}},
        '{gtpc_pkg::MAP_JET,    8'd64,  1'b0, '0},
        '{gtpc_pkg::MAP_HOT,    8'd0,   1'b1, {8'd0,   8'd0,   8'd0}},
        '{gtpc_pkg::MAP_HOT,    8'd255, 1'b1, {8'd255, 8'd255, 8'd255}},
        '{gtpc_pkg::MAP_HOT,    8'd85,  1'b0, '0},
        '{gtpc_pkg::MAP_HOT,    8'd170, 1'b0, '0},
        '{gtpc_pkg::MAP_HSV,    8'd0,   1'b1, {8'd255, 8'd0,   8'd0}},
        '{gtpc_pkg::MAP_HSV,    8'd255, 1'b1, {8'd0,   8'd0,   8'd0}},
        '{gtpc_pkg::MAP_HSV,    8'd85,  1'b0, '0},
        '{gtpc_pkg::MAP_HSV,    8'd42,  1'b0, '0},
        '{gtpc_pkg::MAP_HSV,    8'd213, 1'b0, '0},
        '{gtpc_pkg::MAP_COOL,   8'd0,   1'b1, {8'd0,   8'd255, 8'd255}},
        '{gtpc_pkg::MAP_COOL,   8'd255, 1'b1, {8'd255, 8'd0,   8'd255}},
        '{gtpc_pkg::MAP_SPRING, 8'd0,   1'b1, {8'd255, 8'd0,   8'd255}},
        '{gtpc_pkg::MAP_SUMMER, 8'd255, 1'b1, {8'd255, 8'd255, 8'd128}},
        '{gtpc_pkg::MAP_SUMMER, 8'd0,   1'b1, {8'd128, 8'd128, 8'd128}},
        '{gtpc_pkg::MAP_AUTUMN, 8'd255, 1'b1, {8'd255, 8'd255, 8'd0}},
        '{gtpc_pkg::MAP_WINTER, 8'd0,   1'b1, {8'd0,   8'd0,   8'd255}},
        '{gtpc_pkg::MAP_BONE,   8'd255, 1'b1, {8'd255, 8'd255, 8'd255}},
        '{gtpc_pkg::MAP_BONE,   8'd213, 1'b0, '0},
        '{UNUSED_MAP_LO,        8'd255, 1'b1, {8'd0,   8'd0,   8'd0}},
        '{UNUSED_MAP_HI,        8'hA5,  1'b1, {8'd0,   8'd0,   8'd0}}
    };

    gray_to_pseudo_color_map i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_color_map (cfg_color_map),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_gray_value  (s_gray_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue)
    );

    function automatic logic [7:0] clip8(input int x);
        if (x < 0) begin
            return 8'd0;
        end
        if (x > 255) begin
            return 8'd255;
        end
        return 8'(x);
    endfunction

    function automatic logic [7:0] hue_ramp(input int f);
        return 8'((4369 * f + 2) >>> 10);
    endfunction

    function automatic gtpc_pkg::rgb_t color_of(input logic [3:0] map,
                                                input logic [7:0] gray);
        int             v;
        int             d;
        int             ad;
        int             hue;
        int             f;
        gtpc_pkg::rgb_t c;
        v = int'(gray);
        d = v - 128;
        ad = (d < 0) ? -d : d;
        hue = (v * 360) / 255;
        c = '0;
        case (map)
            gtpc_pkg::MAP_JET: begin
                c.red   = clip8(d > 0 ? (255 * d) / 128 : 0);
                c.green = clip8((255 * (255 - ad)) / 128);
                c.blue  = clip8(d < 0 ? (255 * -d) / 128 : 0);
            end
            gtpc_pkg::MAP_HOT: begin
                c.red   = clip8(3 * v);
                c.green = clip8(3 * v - 255);
                c.blue  = clip8(3 * v - 510);
            end
            gtpc_pkg::MAP_HSV: begin
                if (hue < 360) begin
                    f = hue % 60;
                    case (gtpc_pkg::sector_t'(hue / 60))
                        gtpc_pkg::SEC_RED:    c = {8'd255, hue_ramp(f), 8'd0};
                        gtpc_pkg::SEC_YELLOW: c = {hue_ramp(60 - f), 8'd255, 8'd0};
                        gtpc_pkg::SEC_GREEN:  c = {8'd0, 8'd255, hue_ramp(f)};
                        gtpc_pkg::SEC_CYAN:   c = {8'd0, hue_ramp(60 - f), 8'd255};
                        gtpc_pkg::SEC_BLUE:   c = {hue_ramp(f), 8'd0, 8'd255};
                        default:              c = {8'd255, 8'd0, hue_ramp(60 - f)};
                    endcase
                end
            end
            gtpc_pkg::MAP_COOL:   c = {gray, 8'd255 - gray, 8'd255};
            gtpc_pkg::MAP_SPRING: c = {8'd255, gray, 8'd255 - gray};
            gtpc_pkg::MAP_SUMMER: c = {(gray >> 1) + 8'd128, (gray >> 1) + 8'd128, 8'd128};
            gtpc_pkg::MAP_AUTUMN: c = {8'd255, gray, 8'd0};
            gtpc_pkg::MAP_WINTER: c = {8'd0, gray, 8'd255 - gray};
            gtpc_pkg::MAP_BONE: begin
                c.red   = clip8((6 * v) / 5);
                c.green = clip8((11 * v) / 10);
                c.blue  = gray;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at color %0d: %s", n_checked, what);
        errors++;
    endtask

    task automatic push_gray(input logic [7:0] gray, input gtpc_pkg::rgb_t want);
        int gap;
        s_valid <= 1'b1;
        s_gray_value <= gray;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        expected_colors.push_back(want);
        n_items++;
        gap = 0;
        if (send_idling && $urandom_range(0, 99) < 35) begin
            gap = idle_length();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_map(input logic [3:0] map);
        s_valid <= 1'b0;
        wait (expected_colors.size() == 0);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_color_map <= map;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_map = map;
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        int wait_left;
        m_ready = 1'b0;
        wait_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
                m_ready <= 1'b1;
            end else if (wait_left > 0) begin
                m_ready <= 1'b0;
                wait_left--;
            end else if (recv_idling && $urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
                wait_left = idle_length() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        gtpc_pkg::rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("color item arrived with none pending");
            end else begin
                want = expected_colors.pop_front();
                n_checked++;
                if (m_red !== want.red) begin
                    report_mismatch($sformatf("red %0d, expected %0d", m_red, want.red));
                end
                if (m_green !== want.green) begin
                    report_mismatch($sformatf("green %0d, expected %0d", m_green, want.green));
                end
                if (m_blue !== want.blue) begin
                    report_mismatch($sformatf("blue %0d, expected %0d", m_blue, want.blue));
                end
            end
        end
    end

    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no progress for %0d cycles with %0d colors pending",
                     QUIET_LIMIT, expected_colors.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int         p;
        int         k;
        logic [3:0] map;
        logic [7:0] gray;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_color_map = '0;
        s_valid = 1'b0;
        s_gray_value = '0;
        cur_map = gtpc_pkg::MAP_JET;
        errors = 0;
        n_items = 0;
        n_checked = 0;
        quiet_cycles = 0;
        send_idling = 1'b0;
        recv_idling = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // The first rows run on the reset value of the selector.
        for (k = 0; k < PROBE_COUNT; k++) begin
            if (probes[k].map != cur_map) begin
                write_map(probes[k].map);
            end
            push_gray(probes[k].gray,
                      probes[k].typed ? probes[k].color : color_of(cur_map, probes[k].gray));
        end

        for (p = 0; p < PHASE_COUNT; p++) begin
            map = (p < 16) ? 4'(p)
                           : 4'($urandom_range(gtpc_pkg::MAP_JET, gtpc_pkg::MAP_BONE));
            write_map(map);
            send_idling = (p % 4) != 1;
            recv_idling = (p % 4) != 2;
            // The output stalls for a long stretch while items keep coming.
            if (p == 3 || p == 11) begin
                hold_request = 1'b1;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: gray = 8'd0;
                        1: gray = 8'd255;
                        2: gray = 8'd127;
                        default: gray = 8'd128;
                    endcase
                end else begin
                    gray = 8'($urandom_range(0, 255));
                end
                push_gray(gray, color_of(cur_map, gray));
            end
        end

        s_valid <= 1'b0;
        wait (expected_colors.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d gray items sent and %0d colors checked across all 16 selector codes,",
                 n_items, n_checked);
        $display("with random gaps on both sides and long output stalls.");
        if (errors == 0 && expected_colors.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/gtpc_pkg.sv
design/gtpc_lin_map.sv
design/gtpc_hsv_sector.sv
design/gray_to_pseudo_color_map.sv
tb/gray_to_pseudo_color_map_test.sv
